@@ design/swhr_pkg.sv @@
// shared types, constants and helpers for the single-wire humidity sensor reader
`timescale 1ns / 1ps

package swhr_pkg;

    localparam int DATA_BITS   = 40;
    localparam int PULSE_W     = 8;
    localparam int FRAME_BYTES = DATA_BITS / 8;
    localparam int ADDR_W      = $clog2(DATA_BITS);
    localparam int SCAN_W      = $clog2(DATA_BITS + 1);
    localparam int BIT_IDX_W   = 6;
    localparam int LEVEL_W     = 8;
    localparam int START_W     = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;

    localparam logic [PULSE_W-1:0] PULSE_MAX = '1;

    localparam logic [START_W-1:0] START_TICKS_RST = 20'd18000;
    localparam logic [LEVEL_W-1:0] MAX_WAIT_RST    = 8'd100;
    localparam logic               WIDE_FORMAT_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_FORMAT = 2'd2;

    // x / 10 == (x * DIV10_MUL) >> DIV10_SHIFT for any 16-bit x
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_TIMEOUT  = 2'd1,
        ERR_CHECKSUM = 2'd2
    } err_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ACK_WAIT,
        ST_ACK_LOW,
        ST_ACK_HIGH,
        ST_BIT_LOW,
        ST_BIT_HIGH,
        ST_SCAN,
        ST_CHECK,
        ST_DIV_MUL,
        ST_DIV_FIX,
        ST_EMIT,
        ST_EMIT_BAD
    } state_t;

    typedef struct packed {
        logic      fetch_init;
        logic      start_tick;
        logic      level_inc;
        logic      level_clear;
        logic      store_pulse;
        logic      scan_step;
        logic      commit_sample;
        logic      div_mul;
        logic      div_fix;
        logic      out_load;
        logic      out_drive_low;
        logic      out_busy;
        logic      out_done;
        err_code_t out_err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_reached;
        logic timeout;
        logic last_bit;
        logic scan_done;
        logic checksum_ok;
        logic slot_free;
    } dp_status_t;

    function automatic logic [PULSE_W-1:0] sat_pulse(input logic [LEVEL_W-1:0] len);
        logic [31:0] wide_len;
        wide_len = 32'(len);
        if (wide_len > 32'(PULSE_MAX)) begin
            return PULSE_MAX;
        end
        return PULSE_W'(len);
    endfunction

endpackage

@@ design/swhr_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module swhr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/swhr_ctrl.sv @@
// controller state machine for the single-wire sensor fetch
`timescale 1ns / 1ps

module swhr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic                s_line_level,
    input  swhr_pkg::dp_status_t status,
    output swhr_pkg::ctrl_cmd_t  cmd
);
    import swhr_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t level_end_next;
    logic   in_phase;
    logic   accept;
    logic   awaited;
    logic   level_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign in_phase = (state_reg == ST_IDLE) || (state_reg == ST_START) ||
                      (state_reg == ST_ACK_WAIT) || (state_reg == ST_ACK_LOW) ||
                      (state_reg == ST_ACK_HIGH) || (state_reg == ST_BIT_LOW) ||
                      (state_reg == ST_BIT_HIGH);
    assign s_ready     = in_phase && status.slot_free;
    assign accept      = s_valid && s_ready;
    assign awaited     = !((state_reg == ST_ACK_LOW) || (state_reg == ST_BIT_LOW));
    assign level_match = (s_line_level == awaited);

    // phase after the awaited level ends
    always_comb begin
        unique case (state_reg)
            ST_ACK_WAIT: level_end_next = ST_ACK_LOW;
            ST_ACK_LOW:  level_end_next = ST_ACK_HIGH;
            ST_ACK_HIGH: level_end_next = ST_BIT_LOW;
            ST_BIT_LOW:  level_end_next = ST_BIT_HIGH;
            ST_BIT_HIGH: level_end_next = status.last_bit ? ST_SCAN : ST_BIT_LOW;
            default:     level_end_next = ST_IDLE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_cmd) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (accept && status.start_reached) begin
                    state_next = ST_ACK_WAIT;
                end
            end
            ST_ACK_WAIT, ST_ACK_LOW, ST_ACK_HIGH, ST_BIT_LOW, ST_BIT_HIGH: begin
                if (accept) begin
                    if (!level_match) begin
                        state_next = level_end_next;
                    end else if (status.timeout) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (status.scan_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.checksum_ok ? ST_DIV_MUL : ST_EMIT_BAD;
            end
            ST_DIV_MUL: begin
                state_next = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                state_next = ST_EMIT;
            end
            ST_EMIT, ST_EMIT_BAD: begin
                if (status.slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.out_err = ERR_OK;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.fetch_init = accept && s_cmd;
            end
            ST_START: begin
                cmd.start_tick  = accept;
                cmd.level_clear = accept && status.start_reached;
            end
            ST_ACK_WAIT, ST_ACK_LOW, ST_ACK_HIGH, ST_BIT_LOW, ST_BIT_HIGH: begin
                if (accept) begin
                    if (!level_match) begin
                        cmd.level_clear = 1'b1;
                        cmd.store_pulse = (state_reg == ST_BIT_HIGH);
                    end else if (status.timeout) begin
                        cmd.out_done = 1'b1;
                        cmd.out_err  = ERR_TIMEOUT;
                    end else begin
                        cmd.level_inc = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
            end
            ST_CHECK: begin
                cmd.commit_sample = status.checksum_ok;
            end
            ST_DIV_MUL: begin
                cmd.div_mul = 1'b1;
            end
            ST_DIV_FIX: begin
                cmd.div_fix = 1'b1;
            end
            ST_EMIT: begin
                cmd.out_load = status.slot_free;
                cmd.out_done = 1'b1;
            end
            ST_EMIT_BAD: begin
                cmd.out_load = status.slot_free;
                cmd.out_done = 1'b1;
                cmd.out_err  = ERR_CHECKSUM;
            end
            default: begin
                cmd.out_load = 1'b0;
            end
        endcase
        if (accept) begin
            cmd.out_load      = (state_next != ST_SCAN);
            cmd.out_drive_low = (state_next == ST_START);
            cmd.out_busy      = (state_next != ST_IDLE);
        end
    end

endmodule

@@ design/swhr_datapath.sv @@
// counters, pulse store, frame decode, divide-by-ten and result register
`timescale 1ns / 1ps

module swhr_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swhr_pkg::ctrl_cmd_t               cmd,
    output swhr_pkg::dp_status_t              status,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [swhr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swhr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_drive_low,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic [1:0]                        m_error_code,
    output logic [12:0]                       m_humidity_whole,
    output logic [3:0]                        m_humidity_tenths,
    output logic [11:0]                       m_temp_whole,
    output logic [3:0]                        m_temp_tenths,
    output logic                              m_temp_negative
);
    import swhr_pkg::*;

    logic [START_W-1:0]   start_ticks_reg;
    logic [LEVEL_W-1:0]   max_wait_reg;
    logic                 wide_format_reg;

    logic [START_W-1:0]   start_counter_reg;
    logic [START_W-1:0]   start_counter_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [BIT_IDX_W-1:0] bit_index_reg;
    logic [PULSE_W-1:0]   shortest_reg;
    logic [PULSE_W-1:0]   longest_reg;
    logic [PULSE_W-1:0]   pulse_len;

    logic [SCAN_W-1:0]    scan_cnt_reg;
    logic                 rd_pend_reg;
    logic                 scan_issue;
    logic [PULSE_W-1:0]   rd_data;
    logic [PULSE_W:0]     thr_sum;
    logic [PULSE_W-1:0]   threshold;
    logic [DATA_BITS-1:0] frame_reg;
    logic [7:0]           frame_byte [FRAME_BYTES];
    logic [7:0]           byte_sum;

    logic [7:0]           sample_reg [4];
    logic [31:0]          hum_prod_reg;
    logic [31:0]          tmp_prod_reg;
    logic [15:0]          hum_val;
    logic [15:0]          tmp_mag;
    logic [12:0]          hum_q;
    logic [11:0]          tmp_q;
    logic [12:0]          hum_q_reg;
    logic [3:0]           hum_r_reg;
    logic [11:0]          tmp_q_reg;
    logic [3:0]           tmp_r_reg;

    logic                 m_valid_reg;
    logic                 drive_low_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [1:0]           err_reg;
    logic [12:0]          hum_whole_reg;
    logic [3:0]           hum_tenths_reg;
    logic [11:0]          tmp_whole_reg;
    logic [3:0]           tmp_tenths_reg;
    logic                 tmp_neg_reg;

    assign start_counter_next = start_counter_reg + START_W'(1);
    assign pulse_len          = sat_pulse(level_reg);
    assign scan_issue         = cmd.scan_step && (scan_cnt_reg < SCAN_W'(DATA_BITS));
    assign thr_sum            = {1'b0, shortest_reg} + {1'b0, longest_reg};
    assign threshold          = thr_sum[PULSE_W:1];

    always_comb begin
        for (int k = 0; k < FRAME_BYTES; k++) begin
            frame_byte[k] = frame_reg[DATA_BITS-1-8*k -: 8];
        end
    end

    assign byte_sum = frame_byte[0] + frame_byte[1] + frame_byte[2] + frame_byte[3];

    assign hum_val = {sample_reg[0], sample_reg[1]};
    assign tmp_mag = {1'b0, sample_reg[2][6:0], sample_reg[3]};
    assign hum_q   = hum_prod_reg[DIV10_SHIFT +: 13];
    assign tmp_q   = tmp_prod_reg[DIV10_SHIFT +: 12];

    assign status.start_reached = (start_counter_next >= start_ticks_reg);
    assign status.timeout       = (level_reg >= max_wait_reg);
    assign status.last_bit      = (bit_index_reg == BIT_IDX_W'(DATA_BITS - 1));
    assign status.scan_done     = (scan_cnt_reg == SCAN_W'(DATA_BITS)) && !rd_pend_reg;
    assign status.checksum_ok   = (byte_sum == frame_byte[FRAME_BYTES-1]);
    assign status.slot_free     = !m_valid_reg || m_ready;

    swhr_ram #(
        .WIDTH (PULSE_W),
        .DEPTH (DATA_BITS)
    ) u_pulse_ram (
        .aclk    (aclk),
        .wr_en   (cmd.store_pulse),
        .wr_addr (bit_index_reg[ADDR_W-1:0]),
        .wr_data (pulse_len),
        .rd_en   (scan_issue),
        .rd_addr (scan_cnt_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // control and reset-valued state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_ticks_reg   <= START_TICKS_RST;
            max_wait_reg      <= MAX_WAIT_RST;
            wide_format_reg   <= WIDE_FORMAT_RST;
            start_counter_reg <= '0;
            level_reg         <= '0;
            bit_index_reg     <= '0;
            shortest_reg      <= PULSE_MAX;
            longest_reg       <= '0;
            scan_cnt_reg      <= '0;
            rd_pend_reg       <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                sample_reg[k] <= '0;
            end
            hum_q_reg         <= '0;
            hum_r_reg         <= '0;
            tmp_q_reg         <= '0;
            tmp_r_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                priority if (cfg_index == CFG_START_TICKS) begin
                    start_ticks_reg <= cfg_data;
                end else if (cfg_index == CFG_MAX_WAIT) begin
                    max_wait_reg <= cfg_data[LEVEL_W-1:0];
                end else if (cfg_index == CFG_WIDE_FORMAT) begin
                    wide_format_reg <= cfg_data[0];
                end
            end

            if (cmd.fetch_init) begin
                start_counter_reg <= '0;
                level_reg         <= '0;
                bit_index_reg     <= '0;
                shortest_reg      <= PULSE_MAX;
                longest_reg       <= '0;
            end else begin
                if (cmd.start_tick) begin
                    start_counter_reg <= start_counter_next;
                end
                if (cmd.level_clear) begin
                    level_reg <= '0;
                end else if (cmd.level_inc) begin
                    level_reg <= level_reg + LEVEL_W'(1);
                end
                if (cmd.store_pulse) begin
                    bit_index_reg <= bit_index_reg + BIT_IDX_W'(1);
                    if (pulse_len < shortest_reg) begin
                        shortest_reg <= pulse_len;
                    end
                    if (pulse_len > longest_reg) begin
                        longest_reg <= pulse_len;
                    end
                end
            end

            if (cmd.store_pulse) begin
                scan_cnt_reg <= '0;
                rd_pend_reg  <= 1'b0;
            end else if (cmd.scan_step) begin
                rd_pend_reg <= scan_issue;
                if (scan_issue) begin
                    scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
                end
            end

            if (cmd.commit_sample) begin
                for (int k = 0; k < 4; k++) begin
                    sample_reg[k] <= frame_byte[k];
                end
            end

            if (cmd.div_fix) begin
                hum_q_reg <= hum_q;
                hum_r_reg <= 4'(hum_val - 16'({hum_q, 3'b000}) - 16'({hum_q, 1'b0}));
                tmp_q_reg <= tmp_q;
                tmp_r_reg <= 4'(tmp_mag - 16'({tmp_q, 3'b000}) - 16'({tmp_q, 1'b0}));
            end

            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.scan_step && rd_pend_reg) begin
            frame_reg <= {frame_reg[DATA_BITS-2:0], (rd_data >= threshold)};
        end
        if (cmd.div_mul) begin
            hum_prod_reg <= 32'(hum_val) * 32'(DIV10_MUL);
            tmp_prod_reg <= 32'(tmp_mag) * 32'(DIV10_MUL);
        end
        if (cmd.out_load) begin
            drive_low_reg <= cmd.out_drive_low;
            busy_reg      <= cmd.out_busy;
            done_reg      <= cmd.out_done;
            err_reg       <= cmd.out_err;
            if (wide_format_reg) begin
                hum_whole_reg  <= hum_q_reg;
                hum_tenths_reg <= hum_r_reg;
                tmp_whole_reg  <= tmp_q_reg;
                tmp_tenths_reg <= tmp_r_reg;
                tmp_neg_reg    <= sample_reg[2][7];
            end else begin
                hum_whole_reg  <= 13'(sample_reg[0]);
                hum_tenths_reg <= '0;
                tmp_whole_reg  <= 12'(sample_reg[2]);
                tmp_tenths_reg <= '0;
                tmp_neg_reg    <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_drive_low       = drive_low_reg;
    assign m_busy_res        = busy_reg;
    assign m_done_res        = done_reg;
    assign m_error_code      = err_reg;
    assign m_humidity_whole  = hum_whole_reg;
    assign m_humidity_tenths = hum_tenths_reg;
    assign m_temp_whole      = tmp_whole_reg;
    assign m_temp_tenths     = tmp_tenths_reg;
    assign m_temp_negative   = tmp_neg_reg;

endmodule

@@ design/single_wire_humidity_sensor_reader.sv @@
// top level of the single-wire humidity and temperature sensor reader
`timescale 1ns / 1ps

// The input channel carries one transfer per sensor tick: s_cmd = 1 starts a
// fetch (ignored while busy), s_cmd = 0 is a plain tick; s_line_level is the
// sampled data line. Every input transfer produces exactly one result
// transfer on the m_ channel with drive_low, busy/done, error code and the
// current humidity and temperature reading.
// The cfg_ channel writes start_ticks (index 0), max_wait_ticks (1) and
// wide_format (2); it is always ready and should only be used while idle.
// An ordinary tick gives its registered result in the cycle after the
// transfer, and the next tick is taken in that same cycle, so one tick per
// cycle while m_ready is high. The tick that ends the 40th data pulse is
// followed by a registered scan of the pulse ram (one read per cycle), the
// checksum, a divide-by-ten if it passes, and the result register load.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the stored sample to zero and returns the block to idle.
// If the receiver stalls m_ready, the result waits in the output register
// and the block takes no further tick until that result is transferred.
module single_wire_humidity_sensor_reader (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic                              s_line_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_drive_low,
    output logic                              m_busy_res,
    output logic                              m_done_res,
    output logic [1:0]                        m_error_code,
    output logic [12:0]                       m_humidity_whole,
    output logic [3:0]                        m_humidity_tenths,
    output logic [11:0]                       m_temp_whole,
    output logic [3:0]                        m_temp_tenths,
    output logic                              m_temp_negative,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swhr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [swhr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import swhr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    swhr_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_line_level (s_line_level),
        .status       (status),
        .cmd          (cmd)
    );

    swhr_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_low       (m_drive_low),
        .m_busy_res        (m_busy_res),
        .m_done_res        (m_done_res),
        .m_error_code      (m_error_code),
        .m_humidity_whole  (m_humidity_whole),
        .m_humidity_tenths (m_humidity_tenths),
        .m_temp_whole      (m_temp_whole),
        .m_temp_tenths     (m_temp_tenths),
        .m_temp_negative   (m_temp_negative)
    );

endmodule
